/* rtl/hpq_pkg.sv */
package hpq_pkg;

	localparam int KEY_W  = 32;
	localparam int FILL_W = 11;

	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_EXTRACT = 2'd1;
	localparam logic [1:0] MODE_PEEK    = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0]  value;
		logic [1:0]        status;
		logic [FILL_W-1:0] fill;
	} rsp_t;

endpackage

/* rtl/hpq_mem.sv */
module hpq_mem import hpq_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [KEY_W-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [KEY_W-1:0] rdata_a,
	output logic [KEY_W-1:0] rdata_b
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* rtl/hpq_seq.sv */
module hpq_seq import hpq_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_t             cmd,
	output logic             res_valid,
	output rsp_t             res,
	input  logic             res_take,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [KEY_W-1:0] mem_wdata,
	output logic [AW-1:0]    mem_raddr_a,
	output logic [AW-1:0]    mem_raddr_b,
	input  logic [KEY_W-1:0] mem_rdata_a,
	input  logic [KEY_W-1:0] mem_rdata_b
);

	localparam int IW = CW + 1;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_UP_RD  = 10'b0000000010,
		S_UP_CMP = 10'b0000000100,
		S_EX_RD  = 10'b0000001000,
		S_EX_CMP = 10'b0000010000,
		S_DN_RD  = 10'b0000100000,
		S_DN_CMP = 10'b0001000000,
		S_PK_RD  = 10'b0010000000,
		S_PK_CMP = 10'b0100000000,
		S_FIN    = 10'b1000000000
	} state_t;

	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    pos_q, pos_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [KEY_W-1:0] res_value_q, res_value_d;
	logic [1:0]       res_status_q, res_status_d;

	logic [AW-1:0]    pos_m1;
	logic [AW-1:0]    parent;
	logic [IW-1:0]    left_idx;
	logic [IW-1:0]    right_idx;
	logic [IW-1:0]    n_ext;
	logic             left_ok;
	logic             right_ok;
	logic             take_left;
	logic             take_right;
	logic [KEY_W-1:0] cmp_val;
	logic [CW-1:0]    count_m1;

	assign pos_m1    = pos_q - AW'(1);
	assign parent    = pos_m1 >> 1;
	assign left_idx  = IW'({pos_q, 1'b1});
	assign right_idx = left_idx + IW'(1);
	assign n_ext     = IW'(count_q);
	assign left_ok   = left_idx < n_ext;
	assign right_ok  = right_idx < n_ext;
	assign take_left = left_ok && (mem_rdata_a > key_q);
	assign cmp_val   = take_left ? mem_rdata_a : key_q;
	assign take_right = right_ok && (mem_rdata_b > cmp_val);
	assign count_m1  = count_q - CW'(1);

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = '{value: res_value_q, status: res_status_q, fill: FILL_W'(count_q)};

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		pos_d        = pos_q;
		key_d        = key_q;
		res_value_d  = res_value_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_waddr    = pos_q;
		mem_wdata    = key_q;
		mem_raddr_a  = '0;
		mem_raddr_b  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					key_d        = cmd.key;
					res_status_d = STATUS_OK;
					res_value_d  = '0;
					case (cmd.mode)
						MODE_INSERT: begin
							res_value_d = cmd.key;
							if (count_q == CW'(DEPTH)) begin
								res_status_d = STATUS_FULL;
								state_d      = S_FIN;
							end else begin
								pos_d   = count_q[AW-1:0];
								count_d = count_q + CW'(1);
								state_d = S_UP_RD;
							end
						end
						MODE_EXTRACT: begin
							if (count_q == '0) begin
								res_status_d = STATUS_EMPTY;
								state_d      = S_FIN;
							end else begin
								state_d = S_EX_RD;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_status_d = STATUS_EMPTY;
								state_d      = S_FIN;
							end else begin
								state_d = S_PK_RD;
							end
						end
					endcase
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_FIN;
				end else begin
					mem_raddr_a = parent;
					state_d     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (mem_rdata_a >= key_q) begin
					state_d = S_FIN;
				end else begin
					mem_wdata = mem_rdata_a;
					pos_d     = parent;
					state_d   = S_UP_RD;
				end
			end
			S_EX_RD: begin
				mem_raddr_a = '0;
				mem_raddr_b = count_m1[AW-1:0];
				state_d     = S_EX_CMP;
			end
			S_EX_CMP: begin
				res_value_d = mem_rdata_a;
				key_d       = mem_rdata_b;
				count_d     = count_m1;
				pos_d       = '0;
				state_d     = (count_m1 == '0) ? S_FIN : S_DN_RD;
			end
			S_DN_RD: begin
				mem_raddr_a = left_idx[AW-1:0];
				mem_raddr_b = right_idx[AW-1:0];
				state_d     = S_DN_CMP;
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (take_right) begin
					mem_wdata = mem_rdata_b;
					pos_d     = right_idx[AW-1:0];
					state_d   = S_DN_RD;
				end else if (take_left) begin
					mem_wdata = mem_rdata_a;
					pos_d     = left_idx[AW-1:0];
					state_d   = S_DN_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_PK_RD: begin
				mem_raddr_a = '0;
				state_d     = S_PK_CMP;
			end
			S_PK_CMP: begin
				res_value_d = mem_rdata_a;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		key_q        <= key_d;
		res_value_q  <= res_value_d;
		res_status_q <= res_status_d;
	end

endmodule

/* rtl/max_heap_priority_queue.sv */
// Binary max-heap priority queue of 32-bit unsigned keys held in one
// two-read, one-write synchronous RAM of DEPTH entries, rooted at entry 0.
// Each cmd transaction is an insert, an extract-max or a peek (mode 3
// peeks) and returns exactly one rsp transaction with the key, a status
// and the new fill. The block takes one operation at a time. Each level
// that the key moves (at most log2(DEPTH)) costs a RAM read state and a
// compare-and-write state (S_UP_RD/S_UP_CMP up, S_DN_RD/S_DN_CMP down). An
// insert to a full queue, or an extract or peek on an empty one, goes
// straight to the result, and a result waits while the response register
// is held by rsp_stall. cmd_stall stays high until the result has moved into
// the response register, which holds one result while the next command is
// being processed. The RAM is never cleared; only entries below the fill
// count are ever used.
module max_heap_priority_queue import hpq_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic             res_valid;
	rsp_t             res;
	logic             res_take;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr_a;
	logic [AW-1:0]    mem_raddr_b;
	logic [KEY_W-1:0] mem_rdata_a;
	logic [KEY_W-1:0] mem_rdata_b;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	hpq_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	hpq_seq #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b)
	);

	assign res_take  = res_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

endmodule

/* bench/heap_checker.sv */
module heap_checker import hpq_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [KEY_W-1:0] heap_keys [DEPTH];
	int unsigned      heap_fill;
	rsp_t             awaited_rsp [$];

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
		input logic [KEY_W-1:0] want);
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic void swap_keys(input int unsigned a, input int unsigned b);
		logic [KEY_W-1:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// Apply one operation to the shadow heap and return the response it owes.
	function automatic rsp_t heap_apply(input cmd_t c);
		rsp_t        r;
		int unsigned pos;
		int unsigned up;
		int unsigned lc;
		int unsigned rc;
		int unsigned big;
		bit          moving;
		r = '0;
		r.status = STATUS_OK;
		if (c.mode == MODE_INSERT) begin
			r.value = c.key;
			if (heap_fill >= DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				pos = heap_fill;
				heap_keys[pos] = c.key;
				heap_fill++;
				moving = 1'b1;
				while (moving && pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_keys[up] >= heap_keys[pos]) begin
						moving = 1'b0;
					end else begin
						swap_keys(up, pos);
						pos = up;
					end
				end
			end
		end else if (c.mode == MODE_EXTRACT) begin
			if (heap_fill == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.value = heap_keys[0];
				heap_fill--;
				if (heap_fill > 0) begin
					heap_keys[0] = heap_keys[heap_fill];
					pos = 0;
					moving = 1'b1;
					while (moving) begin
						big = pos;
						lc = 2 * pos + 1;
						rc = lc + 1;
						if (lc < heap_fill && heap_keys[lc] > heap_keys[big])
							big = lc;
						if (rc < heap_fill && heap_keys[rc] > heap_keys[big])
							big = rc;
						if (big == pos) begin
							moving = 1'b0;
						end else begin
							swap_keys(big, pos);
							pos = big;
						end
					end
				end
			end
		end else begin
			// peek, and the unused mode code behaves the same
			if (heap_fill == 0)
				r.status = STATUS_EMPTY;
			else
				r.value = heap_keys[0];
		end
		r.fill = heap_fill[FILL_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
			heap_fill = 0;
			awaited_rsp.delete();
		end else begin
			// a response never belongs to a command taken at the same edge
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch("unexpected rsp value", rsp.value, '0);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.value !== want.value)
						report_mismatch("value", rsp.value, want.value);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.fill !== want.fill)
						report_mismatch("fill", rsp.fill, want.fill);
				end
			end
			if (cmd_valid && !cmd_stall)
				awaited_rsp.push_back(heap_apply(cmd));
			pending = awaited_rsp.size();
		end
	end

endmodule

/* bench/tb.sv */
module tb import hpq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         DEPTH       = 1024;
	localparam int         CYCLE_LIMIT = 800000;
	localparam int         LONG_HOLD   = 400;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int pending;
	int n_sent     = 0;
	int tb_fill    = 0;
	int cycles     = 0;

	always #2 clk = ~clk;

	max_heap_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	heap_checker #(.DEPTH(DEPTH)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(15);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [1:0] pick_mode(input int ins_pct, input int ext_pct);
		int r;
		r = $urandom_range(99);
		if (r < ins_pct)
			return MODE_INSERT;
		if (r < ins_pct + ext_pct)
			return MODE_EXTRACT;
		return (r % 4 == 0) ? MODE_UNUSED : MODE_PEEK;
	endfunction

	task automatic send_cmd(input logic [1:0] m, input logic [KEY_W-1:0] k);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{mode: m, key: k};
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		n_sent++;
		if (m == MODE_INSERT && tb_fill < DEPTH)
			tb_fill++;
		else if (m == MODE_EXTRACT && tb_fill > 0)
			tb_fill--;
	endtask

	task automatic send_random(input int count, input int ins_pct, input int ext_pct);
		repeat (count) send_cmd(pick_mode(ins_pct, ext_pct), pick_key());
	endtask

	// response side: random stall bursts, one long hold-off to back up the block
	initial begin
		int  stall_len;
		int  free_len;
		int  r;
		bit  long_done;
		long_done = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			r = $urandom_range(99);
			stall_len = (r < 55) ? 0 : (r < 90) ? $urandom_range(3, 1) :
				$urandom_range(40, 8);
			r = $urandom_range(99);
			free_len = (r < 80) ? $urandom_range(4, 1) : $urandom_range(200, 30);
			if (!long_done && n_sent >= 120) begin
				stall_len = LONG_HOLD;
				long_done = 1'b1;
			end
			if (stall_len > 0) begin
				rsp_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat (free_len) @(posedge clk);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty heap, then extremes, ties and the unused mode code
		send_cmd(MODE_EXTRACT, 32'h1234_5678);
		send_cmd(MODE_PEEK, '1);
		send_cmd(MODE_UNUSED, '0);
		send_cmd(MODE_INSERT, '0);
		send_cmd(MODE_PEEK, '0);
		send_cmd(MODE_INSERT, '1);
		send_cmd(MODE_UNUSED, '1);
		send_cmd(MODE_INSERT, 32'd5);
		send_cmd(MODE_INSERT, 32'd5);
		send_cmd(MODE_INSERT, 32'd5);
		send_cmd(MODE_INSERT, 32'd7);
		send_cmd(MODE_INSERT, 32'h8000_0000);
		send_cmd(MODE_INSERT, 32'h7FFF_FFFF);
		send_cmd(MODE_INSERT, '1);
		send_cmd(MODE_INSERT, 32'hAAAA_AAAA);
		send_cmd(MODE_INSERT, 32'h5555_5555);
		repeat (9) send_cmd(MODE_EXTRACT, pick_key());
		send_cmd(MODE_EXTRACT, '0);
		send_cmd(MODE_PEEK, '0);

		send_random(250, 45, 35);

		// fill to capacity, hover at full, then drain
		while (tb_fill < DEPTH)
			send_cmd(pick_mode(96, 2), pick_key());
		send_random(60, 70, 20);
		send_random(450, 10, 80);

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
